// ===== rtl/mips_integer_core_step_assert.svh =====
// ----------------------------------------------------------------------------
// MIPS integer core step - assertion macros
// Concurrent check macros used by the datapath; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef MIPS_INTEGER_CORE_STEP_ASSERT_SVH
`define MIPS_INTEGER_CORE_STEP_ASSERT_SVH
`ifndef SYNTH
`define MICS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MICS_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define MICS_ASSERT(lbl, prop, msg)
`define MICS_NEVER(lbl, expr, msg)
`endif
`endif

// ===== rtl/mics_pkg.sv =====
// ----------------------------------------------------------------------------
// MIPS integer core step - package
// Codes, opcodes, sequencer states and the controller/datapath link types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package mics_pkg;

    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_EXEC = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_HALT = 2'd1;
    localparam logic [1:0] STAT_ERR  = 2'd2;

    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_JAL   = 6'h03;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_BNE   = 6'h05;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_ADDIU = 6'h09;
    localparam logic [5:0] OP_SLTI  = 6'h0A;
    localparam logic [5:0] OP_SLTIU = 6'h0B;
    localparam logic [5:0] OP_ANDI  = 6'h0C;
    localparam logic [5:0] OP_ORI   = 6'h0D;
    localparam logic [5:0] OP_LUI   = 6'h0F;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_LBU   = 6'h24;
    localparam logic [5:0] OP_LHU   = 6'h25;
    localparam logic [5:0] OP_SB    = 6'h28;
    localparam logic [5:0] OP_SH    = 6'h29;
    localparam logic [5:0] OP_SW    = 6'h2B;
    localparam logic [5:0] OP_LL    = 6'h30;
    localparam logic [5:0] OP_SC    = 6'h38;

    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_JALR = 6'h09;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLT  = 6'h2A;
    localparam logic [5:0] FN_SLTU = 6'h2B;

    localparam logic [31:0] PC_HALT   = 32'hFFFF_FFFF;
    localparam logic [31:0] SP_RESET  = 32'h0100_0000;
    localparam logic [31:0] RA_RESET  = 32'hFFFF_FFFF;
    localparam logic [31:0] HI_MASK   = 32'hFFFF_0000;
    localparam logic [31:0] SEG_MASK  = 32'hF000_0000;
    localparam logic [31:0] BYTE_MASK = 32'h0000_00FF;
    localparam logic [31:0] HALF_MASK = 32'h0000_FFFF;
    localparam logic [31:0] BYTE_KEEP = 32'hFFFF_FF00;
    localparam logic [4:0]  REG_ZERO  = 5'd0;
    localparam logic [4:0]  REG_V0    = 5'd2;
    localparam logic [4:0]  REG_SP    = 5'd29;
    localparam logic [4:0]  REG_RA    = 5'd31;

    typedef enum logic [2:0] {
        MOP_NONE,
        MOP_LOADW,
        MOP_LOADB,
        MOP_LOADH,
        MOP_STOREW,
        MOP_STOREB,
        MOP_STOREH
    } mem_op_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOADW,
        S_FETCH,
        S_INS,
        S_RS,
        S_EXEC,
        S_MEM,
        S_WB,
        S_RDSEL,
        S_DONE
    } fsm_state_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic load_mem;
        logic fetch;
        logic cap_ins;
        logic cap_a;
        logic exec;
        logic mem;
        logic wb;
        logic rd_sel;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic       clear_done;
        logic [1:0] func;
        logic       skip;
        logic       illegal;
        logic       out_free;
    } sts_t;

    function automatic logic [31:0] gpr_reset_value(input logic [4:0] idx);
        logic [31:0] val;
        val = '0;
        if (idx == REG_SP) val = SP_RESET;
        if (idx == REG_RA) val = RA_RESET;
        return val;
    endfunction

endpackage

// ===== rtl/mics_req_if.sv =====
// ----------------------------------------------------------------------------
// MIPS integer core step - request channel
// Valid/ready channel that carries one command item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface mics_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [11:0] target_index;
    logic [31:0] load_word;

    modport source (output valid, func, target_index, load_word, input ready);
    modport sink   (input valid, func, target_index, load_word, output ready);
endinterface

// ===== rtl/mics_rsp_if.sv =====
// ----------------------------------------------------------------------------
// MIPS integer core step - response channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface mics_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] pc_after;
    logic [31:0] read_value;
    logic [31:0] rtype_count;
    logic [31:0] itype_count;
    logic [31:0] jtype_count;
    logic [31:0] word_access_count;
    logic [31:0] branch_tally;
    logic [31:0] step_count;

    modport source (output valid, status, pc_after, read_value, rtype_count, itype_count,
                    jtype_count, word_access_count, branch_tally, step_count,
                    input ready);
    modport sink   (input valid, status, pc_after, read_value, rtype_count, itype_count,
                    jtype_count, word_access_count, branch_tally, step_count,
                    output ready);
endinterface

// ===== rtl/mips_integer_core_step.sv =====
// ----------------------------------------------------------------------------
// MIPS integer core step - top level
// Multicycle MIPS32 integer core driven one command item at a time.
// ----------------------------------------------------------------------------
// After reset the core runs a clearing pass that zeroes the word memory and
// seeds the register file (sp and ra get their start values); no request
// transfer is taken during that pass. Every request then produces exactly one
// response. For an executed instruction the sequencer walks fetch, register
// reads, execute, memory access and write-back over the single read port of
// each synchronous RAM; an unsupported instruction skips memory access and
// write-back, and a halted or stopped core skips the instruction entirely.
// The response sits in an output register; the next request is taken while it
// waits. MEM_WORDS must be a power of two.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mips_integer_core_step #(
    parameter int MEM_WORDS = 4096
) (
    input logic        clk,
    input logic        rst_n,
    mics_req_if.sink   req,
    mics_rsp_if.source rsp
);
    mics_pkg::cmd_t cmd;
    mics_pkg::sts_t sts;

    // sequencer: owns the request handshake
    mics_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .sts      (sts),
        .in_ready (req.ready),
        .cmd      (cmd)
    );

    // datapath: state, memories and the response register
    mics_dpath #(.MEM_WORDS(MEM_WORDS)) u_dpath (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cmd                   (cmd),
        .sts                   (sts),
        .in_valid              (req.valid),
        .in_func               (req.func),
        .in_target_index       (req.target_index),
        .in_load_word          (req.load_word),
        .out_valid             (rsp.valid),
        .out_ready             (rsp.ready),
        .out_status            (rsp.status),
        .out_pc_after          (rsp.pc_after),
        .out_read_value        (rsp.read_value),
        .out_rtype_count       (rsp.rtype_count),
        .out_itype_count       (rsp.itype_count),
        .out_jtype_count       (rsp.jtype_count),
        .out_word_access_count (rsp.word_access_count),
        .out_branch_tally      (rsp.branch_tally),
        .out_step_count        (rsp.step_count)
    );
endmodule

// ===== rtl/mics_ram.sv =====
// ----------------------------------------------------------------------------
// MIPS integer core step - generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mics_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/mics_ctrl.sv =====
// ----------------------------------------------------------------------------
// MIPS integer core step - sequencer
// State machine that steps the datapath through one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mics_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  mics_pkg::sts_t sts,
    output logic           in_ready,
    output mics_pkg::cmd_t cmd
);
    mics_pkg::fsm_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mics_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mics_pkg::S_CLEAR:
                if (sts.clear_done) state_next = mics_pkg::S_IDLE;
            mics_pkg::S_IDLE:
                if (in_valid)
                begin
                    state_next = mics_pkg::S_RDSEL;
                end
            mics_pkg::S_LOADW: state_next = mics_pkg::S_RDSEL;
            mics_pkg::S_FETCH: state_next = mics_pkg::S_INS;
            mics_pkg::S_INS:   state_next = mics_pkg::S_RS;
            mics_pkg::S_RS:    state_next = mics_pkg::S_EXEC;
            mics_pkg::S_EXEC:
                state_next = sts.illegal ? mics_pkg::S_RDSEL : mics_pkg::S_MEM;
            mics_pkg::S_MEM:   state_next = mics_pkg::S_WB;
            mics_pkg::S_WB:    state_next = mics_pkg::S_RDSEL;
            mics_pkg::S_RDSEL: state_next = mics_pkg::S_DONE;
            mics_pkg::S_DONE:
                if (sts.out_free) state_next = mics_pkg::S_IDLE;
            default: state_next = mics_pkg::S_IDLE;
        endcase
        // the accepted item's function picks the path out of idle
        if (state_reg == mics_pkg::S_IDLE && in_valid)
        begin
            priority if (sts.func == mics_pkg::FUNC_LOAD)
                state_next = mics_pkg::S_LOADW;
            else if (sts.func == mics_pkg::FUNC_EXEC && !sts.skip)
                state_next = mics_pkg::S_FETCH;
            else
                state_next = mics_pkg::S_RDSEL;
        end
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            mics_pkg::S_CLEAR: cmd.clear    = 1'b1;
            mics_pkg::S_IDLE:  cmd.accept   = 1'b1;
            mics_pkg::S_LOADW: cmd.load_mem = 1'b1;
            mics_pkg::S_FETCH: cmd.fetch    = 1'b1;
            mics_pkg::S_INS:   cmd.cap_ins  = 1'b1;
            mics_pkg::S_RS:    cmd.cap_a    = 1'b1;
            mics_pkg::S_EXEC:  cmd.exec     = 1'b1;
            mics_pkg::S_MEM:   cmd.mem      = 1'b1;
            mics_pkg::S_WB:    cmd.wb       = 1'b1;
            mics_pkg::S_RDSEL: cmd.rd_sel   = 1'b1;
            mics_pkg::S_DONE:  cmd.finish   = sts.out_free;
            default:           cmd = '0;
        endcase
    end

    assign in_ready = cmd.accept;
endmodule

// ===== rtl/mics_dpath.sv =====
// ----------------------------------------------------------------------------
// MIPS integer core step - datapath
// Architectural state, decode, ALU, memories and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mips_integer_core_step_assert.svh"
module mics_dpath #(
    parameter int MEM_WORDS = 4096
) (
    input  logic           clk,
    input  logic           rst_n,
    input  mics_pkg::cmd_t cmd,
    output mics_pkg::sts_t sts,
    input  logic           in_valid,
    input  logic [1:0]     in_func,
    input  logic [11:0]    in_target_index,
    input  logic [31:0]    in_load_word,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [1:0]     out_status,
    output logic [31:0]    out_pc_after,
    output logic [31:0]    out_read_value,
    output logic [31:0]    out_rtype_count,
    output logic [31:0]    out_itype_count,
    output logic [31:0]    out_jtype_count,
    output logic [31:0]    out_word_access_count,
    output logic [31:0]    out_branch_tally,
    output logic [31:0]    out_step_count
);
    localparam int AW = $clog2(MEM_WORDS);

    // item fields
    logic [1:0]  func_reg;
    logic [11:0] tix_reg;
    logic [31:0] lw_reg;

    // architectural state
    logic [31:0] pc_reg;
    logic        stopped_reg;
    logic [31:0] cnt_r_reg, cnt_i_reg, cnt_j_reg, cnt_mem_reg, cnt_br_reg, cnt_step_reg;
    logic [AW-1:0] clr_reg;

    // instruction in flight
    logic [31:0]       ins_reg, a_reg, b_reg, res_reg;
    logic [4:0]        wdst_reg;
    logic              wen_reg;
    mics_pkg::mem_op_t mop_reg;
    logic [AW-1:0]     ea_reg;

    // result register
    logic        out_valid_reg;
    logic [1:0]  o_status_reg;
    logic [31:0] o_pc_reg, o_rv_reg;
    logic [31:0] o_r_reg, o_i_reg, o_j_reg, o_mem_reg, o_br_reg, o_step_reg;

    // memory ports
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [31:0]   mem_wdata, mem_rdata;
    logic          gpr_we, gpr_re;
    logic [4:0]    gpr_waddr, gpr_raddr;
    logic [31:0]   gpr_wdata, gpr_rdata;

    // decode and execute
    logic [5:0]        op, fn;
    logic [4:0]        rs_f, rt_f, rd_f, sh_f;
    logic [31:0]       imm, sext, ex_b, pc4, ea;
    logic              ex_legal, ex_wen;
    logic [4:0]        ex_wdst;
    logic [31:0]       ex_res, ex_npc;
    mics_pkg::mem_op_t ex_mop;
    logic [AW+11:0]    tix_wide;
    logic [31:0]       load_val, merge_val;
    logic              mop_reads;

    assign op   = ins_reg[31:26];
    assign rs_f = ins_reg[25:21];
    assign rt_f = ins_reg[20:16];
    assign rd_f = ins_reg[15:11];
    assign sh_f = ins_reg[10:6];
    assign fn   = ins_reg[5:0];
    assign imm  = ins_reg & mics_pkg::HALF_MASK;
    assign sext = {{16{ins_reg[15]}}, ins_reg[15:0]};
    assign ex_b = gpr_rdata;
    assign pc4  = pc_reg + 32'd4;
    assign ea   = a_reg + sext;

    always_comb
    begin
        ex_legal = 1'b1;
        ex_wen   = 1'b0;
        ex_wdst  = rt_f;
        ex_res   = '0;
        ex_npc   = pc4;
        ex_mop   = mics_pkg::MOP_NONE;
        if (op == mics_pkg::OP_RTYPE)
        begin
            ex_wdst = rd_f;
            ex_wen  = 1'b1;
            unique case (fn)
                mics_pkg::FN_ADD, mics_pkg::FN_ADDU: ex_res = a_reg + ex_b;
                mics_pkg::FN_SUB, mics_pkg::FN_SUBU: ex_res = a_reg - ex_b;
                mics_pkg::FN_AND:  ex_res = a_reg & ex_b;
                mics_pkg::FN_OR:   ex_res = a_reg | ex_b;
                mics_pkg::FN_NOR:  ex_res = ~(a_reg | ex_b);
                mics_pkg::FN_SLT:  ex_res = {31'd0, $signed(a_reg) < $signed(ex_b)};
                mics_pkg::FN_SLTU: ex_res = {31'd0, a_reg < ex_b};
                mics_pkg::FN_SLL:  ex_res = ex_b << sh_f;
                mics_pkg::FN_SRL:  ex_res = ex_b >> sh_f;
                mics_pkg::FN_JR:
                begin
                    ex_wen = 1'b0;
                    ex_npc = a_reg;
                end
                mics_pkg::FN_JALR:
                begin
                    ex_res = pc4;
                    ex_npc = a_reg;
                end
                default:
                begin
                    ex_wen   = 1'b0;
                    ex_legal = 1'b0;
                end
            endcase
        end
        else if (op == mics_pkg::OP_J || op == mics_pkg::OP_JAL)
        begin
            ex_wdst = mics_pkg::REG_RA;
            ex_wen  = (op == mics_pkg::OP_JAL);
            ex_res  = pc_reg + 32'd8;
            ex_npc  = (pc4 & mics_pkg::SEG_MASK) | {4'd0, ins_reg[25:0], 2'b00};
        end
        else
        begin
            ex_wen = 1'b1;
            unique case (op)
                mics_pkg::OP_ADDI, mics_pkg::OP_ADDIU: ex_res = ea;
                mics_pkg::OP_ANDI:  ex_res = a_reg & imm;
                mics_pkg::OP_ORI:   ex_res = a_reg | imm;
                mics_pkg::OP_SLTI:  ex_res = {31'd0, $signed(a_reg) < $signed(sext)};
                mics_pkg::OP_SLTIU: ex_res = {31'd0, a_reg < sext};
                mics_pkg::OP_LUI:   ex_res = {ins_reg[15:0], 16'd0};
                mics_pkg::OP_BEQ, mics_pkg::OP_BNE:
                begin
                    ex_wen = 1'b0;
                    if ((op == mics_pkg::OP_BEQ) == (a_reg == ex_b))
                        ex_npc = pc4 + {sext[29:0], 2'b00};
                end
                mics_pkg::OP_LW, mics_pkg::OP_LL: ex_mop = mics_pkg::MOP_LOADW;
                mics_pkg::OP_LBU: ex_mop = mics_pkg::MOP_LOADB;
                mics_pkg::OP_LHU: ex_mop = mics_pkg::MOP_LOADH;
                mics_pkg::OP_SW:
                begin
                    ex_wen = 1'b0;
                    ex_mop = mics_pkg::MOP_STOREW;
                end
                mics_pkg::OP_SB:
                begin
                    ex_wen = 1'b0;
                    ex_mop = mics_pkg::MOP_STOREB;
                end
                mics_pkg::OP_SH:
                begin
                    ex_wen = 1'b0;
                    ex_mop = mics_pkg::MOP_STOREH;
                end
                mics_pkg::OP_SC:
                begin
                    ex_res = 32'd1;
                    ex_mop = mics_pkg::MOP_STOREW;
                end
                default:
                begin
                    ex_wen   = 1'b0;
                    ex_legal = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            stopped_reg   <= 1'b0;
            cnt_r_reg     <= '0;
            cnt_i_reg     <= '0;
            cnt_j_reg     <= '0;
            cnt_mem_reg   <= '0;
            cnt_br_reg    <= '0;
            cnt_step_reg  <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.exec)
            begin
                if (op == mics_pkg::OP_RTYPE)
                    cnt_r_reg <= cnt_r_reg + 32'd1;
                else if (op == mics_pkg::OP_J || op == mics_pkg::OP_JAL)
                    cnt_j_reg <= cnt_j_reg + 32'd1;
                else
                    cnt_i_reg <= cnt_i_reg + 32'd1;
                if (op == mics_pkg::OP_LW || op == mics_pkg::OP_SW)
                    cnt_mem_reg <= cnt_mem_reg + 32'd1;
                if (op == mics_pkg::OP_BEQ || op == mics_pkg::OP_BNE)
                    cnt_br_reg <= cnt_br_reg + 32'd1;
                if (ex_legal)
                begin
                    pc_reg       <= ex_npc;
                    cnt_step_reg <= cnt_step_reg + 32'd1;
                end
                else
                begin
                    stopped_reg <= 1'b1;
                end
            end
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept && in_valid)
        begin
            func_reg <= in_func;
            tix_reg  <= in_target_index;
            lw_reg   <= in_load_word;
        end
        if (cmd.cap_ins)
            ins_reg <= mem_rdata;
        if (cmd.cap_a)
            a_reg <= gpr_rdata;
        if (cmd.exec)
        begin
            b_reg    <= ex_b;
            res_reg  <= ex_res;
            wdst_reg <= ex_wdst;
            wen_reg  <= ex_wen && ex_legal;
            mop_reg  <= ex_legal ? ex_mop : mics_pkg::MOP_NONE;
            ea_reg   <= ea[AW+1:2];
        end
        if (cmd.finish)
        begin
            o_status_reg <= stopped_reg ? mics_pkg::STAT_ERR :
                            (pc_reg == mics_pkg::PC_HALT) ? mics_pkg::STAT_HALT :
                            mics_pkg::STAT_OK;
            o_pc_reg   <= pc_reg;
            o_rv_reg   <= gpr_rdata;
            o_r_reg    <= cnt_r_reg;
            o_i_reg    <= cnt_i_reg;
            o_j_reg    <= cnt_j_reg;
            o_mem_reg  <= cnt_mem_reg;
            o_br_reg   <= cnt_br_reg;
            o_step_reg <= cnt_step_reg;
        end
    end

    // word memory ports
    assign tix_wide  = {{AW{1'b0}}, tix_reg};
    assign mop_reads = (mop_reg == mics_pkg::MOP_LOADW) || (mop_reg == mics_pkg::MOP_LOADB) ||
                       (mop_reg == mics_pkg::MOP_LOADH) || (mop_reg == mics_pkg::MOP_STOREB) ||
                       (mop_reg == mics_pkg::MOP_STOREH);
    assign merge_val = (mop_reg == mics_pkg::MOP_STOREB) ?
                       ((mem_rdata & mics_pkg::BYTE_KEEP) | (b_reg & mics_pkg::BYTE_MASK)) :
                       ((mem_rdata & mics_pkg::HI_MASK) | (b_reg & mics_pkg::HALF_MASK));

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = ea_reg;
        mem_wdata = b_reg;
        priority if (cmd.clear)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end
        else if (cmd.load_mem)
        begin
            mem_we    = 1'b1;
            mem_waddr = tix_wide[AW-1:0];
            mem_wdata = lw_reg;
        end
        else if (cmd.mem && mop_reg == mics_pkg::MOP_STOREW)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.wb && (mop_reg == mics_pkg::MOP_STOREB ||
                            mop_reg == mics_pkg::MOP_STOREH))
        begin
            mem_we    = 1'b1;
            mem_wdata = merge_val;
        end
        else
        begin
            mem_we = 1'b0;
        end
    end

    assign mem_re    = cmd.fetch || (cmd.mem && mop_reads);
    assign mem_raddr = cmd.fetch ? pc_reg[AW+1:2] : ea_reg;

    // register file ports
    always_comb
    begin
        unique case (mop_reg)
            mics_pkg::MOP_LOADW: load_val = mem_rdata;
            mics_pkg::MOP_LOADB: load_val = mem_rdata & mics_pkg::BYTE_MASK;
            mics_pkg::MOP_LOADH: load_val = mem_rdata & mics_pkg::HALF_MASK;
            default:             load_val = res_reg;
        endcase
    end

    always_comb
    begin
        gpr_we    = 1'b0;
        gpr_waddr = wdst_reg;
        gpr_wdata = load_val;
        if (cmd.clear)
        begin
            // seed the register file while the clear counter is below 32
            gpr_we    = (clr_reg[AW-1:5] == '0);
            gpr_waddr = clr_reg[4:0];
            gpr_wdata = mics_pkg::gpr_reset_value(clr_reg[4:0]);
        end
        else if (cmd.wb)
        begin
            gpr_we = wen_reg && (wdst_reg != mics_pkg::REG_ZERO);
        end
    end

    assign gpr_re = cmd.cap_ins || cmd.cap_a || cmd.rd_sel;
    always_comb
    begin
        priority if (cmd.cap_ins)
            gpr_raddr = mem_rdata[25:21];
        else if (cmd.cap_a)
            gpr_raddr = rt_f;
        else if (func_reg == mics_pkg::FUNC_READ)
            gpr_raddr = tix_reg[4:0];
        else
            gpr_raddr = mics_pkg::REG_V0;
    end

    mics_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    mics_ram #(.WIDTH(32), .DEPTH(32)) u_gpr (
        .clk   (clk),
        .we    (gpr_we),
        .waddr (gpr_waddr),
        .wdata (gpr_wdata),
        .re    (gpr_re),
        .raddr (gpr_raddr),
        .rdata (gpr_rdata)
    );

    assign sts.clear_done = (clr_reg == AW'(MEM_WORDS - 1));
    assign sts.func       = in_func;
    assign sts.skip       = stopped_reg || (pc_reg == mics_pkg::PC_HALT);
    assign sts.illegal    = !ex_legal;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid             = out_valid_reg;
    assign out_status            = o_status_reg;
    assign out_pc_after          = o_pc_reg;
    assign out_read_value        = o_rv_reg;
    assign out_rtype_count       = o_r_reg;
    assign out_itype_count       = o_i_reg;
    assign out_jtype_count       = o_j_reg;
    assign out_word_access_count = o_mem_reg;
    assign out_branch_tally      = o_br_reg;
    assign out_step_count        = o_step_reg;

    `MICS_ASSERT(a_err_sticky, stopped_reg |=> stopped_reg, "error flag dropped")
    `MICS_NEVER(a_r0_write, gpr_we && !cmd.clear && gpr_waddr == mics_pkg::REG_ZERO, "r0 written")
    `MICS_ASSERT(a_pc_hold, !cmd.exec |=> $stable(pc_reg), "pc moved outside execute")
    `MICS_NEVER(a_out_overrun, cmd.finish && out_valid_reg && !out_ready, "result overwritten")
endmodule
